// ===== rtl/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and fixed widths of the stream byte reassembler.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFS_W      = 32;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned IN_DATA_W  = 40;  // seg_byte, stream_offset
  localparam int unsigned IN_USER_W  = 2;   // has_byte, eof_here
  localparam int unsigned OUT_DATA_W = 48;  // out_byte, out_offset, stream_closed, pending_count

  // operation of the shared 32-bit adder
  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // control of the byte ring for one cycle
  typedef struct packed {
    logic wr;   // store a byte and set its valid mark
    logic rd;   // read the byte at the head
    logic clr;  // clear the valid mark at the head
  } ring_ctl_t;

endpackage

// ===== rtl/sbr_alu.sv =====
// ----------------------------------------------------------------------------
// sbr_alu
// Shared 32-bit add/subtract unit with zero detect, used for every offset
// computation of the sequencer.
// ----------------------------------------------------------------------------
module sbr_alu (
  input  sbr_pkg::alu_op_t               op,
  input  logic [sbr_pkg::OFS_W-1:0]      opa,
  input  logic [sbr_pkg::OFS_W-1:0]      opb,
  output logic [sbr_pkg::OFS_W-1:0]      res,
  output logic                           zero
);

  always_comb begin
    case (op)
      sbr_pkg::ALU_ADD: res = opa + opb;
      sbr_pkg::ALU_SUB: res = opa - opb;
      default:          res = opa + opb;
    endcase
  end

  assign zero = (res == '0);

endmodule

// ===== rtl/sbr_ring.sv =====
// ----------------------------------------------------------------------------
// sbr_ring
// Byte ring with one write and one registered read port, plus a valid mark
// per slot held in flip-flops.
// ----------------------------------------------------------------------------
module sbr_ring #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbr_pkg::ring_ctl_t            ctl,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [sbr_pkg::BYTE_W-1:0]    wr_data,
  input  logic [AW-1:0]                 head,
  output logic [sbr_pkg::BYTE_W-1:0]    rd_data,
  output logic [DEPTH-1:0]              valid_marks
);

  logic [sbr_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic [DEPTH-1:0]           valid_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[head];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.wr) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (ctl.clr) begin
      valid_nxt[head] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign valid_marks = valid_r;

endmodule

// ===== rtl/stream_byte_reassembler_unit.sv =====
// A request with a byte steps through S_DIST, S_LIM and S_WRITE, where the byte is
// stored, after S_EOF first when it carries an end mark; the drain then alternates
// S_DRAIN and S_EMIT per emitted byte and holds while out_tready is low. A new request
// is taken only in S_IDLE, once the offset steps of the last one in the shared adder end.
// Reset (rst_n low, synchronous): valid marks, offsets, counts and the closed
// flag clear, window_size returns to 64; ring bytes are not cleared.
// ----------------------------------------------------------------------------
// stream_byte_reassembler_unit
// Reassembly window of a byte stream: stores bytes by offset, drains the
// contiguous run in order at each segment end and tracks stream close.
// ----------------------------------------------------------------------------
module stream_byte_reassembler_unit #(
  parameter int unsigned WINDOW_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [sbr_pkg::CNT_W-1:0]         cfg_wr_data,    // window_size
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sbr_pkg::IN_DATA_W-1:0]     in_tdata,       // seg_byte, stream_offset
  input  logic [sbr_pkg::IN_USER_W-1:0]     in_tuser,       // has_byte, eof_here
  input  logic                              in_tlast,       // seg_last
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sbr_pkg::OUT_DATA_W-1:0]    out_tdata,      // out_byte, out_offset,
                                                            // stream_closed, pending_count
  output logic                              out_tuser,      // out_valid
  output logic                              out_tlast       // run_last
);

  localparam int unsigned IW = $clog2(WINDOW_BYTES);
  localparam logic [sbr_pkg::CNT_W-1:0] WinMax  = sbr_pkg::CNT_W'(WINDOW_BYTES);
  localparam logic [IW:0]               RingLen = (IW+1)'(WINDOW_BYTES);
  localparam logic [IW-1:0]             RingTop = IW'(WINDOW_BYTES - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EOF   = 7'b0000010,
    S_DIST  = 7'b0000100,
    S_LIM   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                         st_r, st_nxt;
  logic [sbr_pkg::CNT_W-1:0]      win_size_r;

  // captured request
  logic [sbr_pkg::BYTE_W-1:0]     rq_byte_r;
  logic                           rq_has_r;
  logic [sbr_pkg::OFS_W-1:0]      rq_off_r;
  logic                           rq_last_r;

  // stream state
  logic [sbr_pkg::OFS_W-1:0]      ne_r, ne_nxt;
  logic [sbr_pkg::OFS_W-1:0]      final_r, final_nxt;
  logic                           known_r, known_nxt;
  logic [sbr_pkg::CNT_W-1:0]      held_r, held_nxt;
  logic                           closed_r, closed_nxt;
  logic [IW-1:0]                  head_r, head_nxt;

  // per-request work
  logic [sbr_pkg::OFS_W-1:0]      dist_r, dist_nxt;
  logic                           ok_r, ok_nxt;

  // result waiting to learn whether it ends the run
  logic                           pend_v_r, pend_v_nxt;
  logic [sbr_pkg::BYTE_W-1:0]     pend_byte_r, pend_byte_nxt;
  logic [sbr_pkg::OFS_W-1:0]      pend_off_r, pend_off_nxt;
  logic [sbr_pkg::CNT_W-1:0]      pend_held_r, pend_held_nxt;

  // output register
  logic                           ov_r, ov_nxt;
  logic [sbr_pkg::OUT_DATA_W-1:0] od_r, od_nxt;
  logic                           ou_r, ou_nxt;
  logic                           ol_r, ol_nxt;

  // shared unit and ring
  sbr_pkg::alu_op_t               alu_op;
  logic [sbr_pkg::OFS_W-1:0]      alu_a, alu_b, alu_res;
  logic                           alu_zero;
  sbr_pkg::ring_ctl_t             ring_ctl;
  logic [IW-1:0]                  wr_idx;
  logic [IW:0]                    idx_sum;
  logic [sbr_pkg::BYTE_W-1:0]     rd_data;
  logic [WINDOW_BYTES-1:0]        valid_marks;

  logic [sbr_pkg::CNT_W-1:0]      win_eff;
  logic                           in_acc;
  logic                           at_final;
  logic                           more;

  assign in_acc  = in_tvalid && in_tready;
  assign win_eff = (win_size_r > WinMax) ? WinMax : win_size_r;

  // ring slot of the stored byte: head plus distance, wrapped once
  assign idx_sum = {1'b0, head_r} + {1'b0, dist_r[IW-1:0]};
  assign wr_idx  = (idx_sum >= RingLen) ? IW'(idx_sum - RingLen) : idx_sum[IW-1:0];

  assign at_final = known_r && alu_zero;
  assign more     = valid_marks[head_r] && !at_final;

  sbr_alu u_alu (
    .op   (alu_op),
    .opa  (alu_a),
    .opb  (alu_b),
    .res  (alu_res),
    .zero (alu_zero)
  );

  sbr_ring #(
    .DEPTH (WINDOW_BYTES),
    .AW    (IW)
  ) u_ring (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ring_ctl),
    .wr_addr     (wr_idx),
    .wr_data     (rq_byte_r),
    .head        (head_r),
    .rd_data     (rd_data),
    .valid_marks (valid_marks)
  );

  // operand selection of the shared unit
  always_comb begin
    alu_op = sbr_pkg::ALU_SUB;
    alu_a  = ne_r;
    alu_b  = final_r;
    case (st_r)
      S_EOF: begin
        alu_op = sbr_pkg::ALU_ADD;
        alu_a  = rq_off_r;
        alu_b  = {{(sbr_pkg::OFS_W-1){1'b0}}, rq_has_r};
      end
      S_DIST: begin
        alu_a = rq_off_r;
        alu_b = ne_r;
      end
      S_LIM: begin
        alu_a = final_r;
        alu_b = ne_r;
      end
      S_EMIT: begin
        alu_op = sbr_pkg::ALU_ADD;
        alu_b  = {{(sbr_pkg::OFS_W-1){1'b0}}, 1'b1};
      end
      default: begin
        alu_op = sbr_pkg::ALU_SUB;
      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    ne_nxt        = ne_r;
    final_nxt     = final_r;
    known_nxt     = known_r;
    held_nxt      = held_r;
    closed_nxt    = closed_r;
    head_nxt      = head_r;
    dist_nxt      = dist_r;
    ok_nxt        = ok_r;
    pend_v_nxt    = pend_v_r;
    pend_byte_nxt = pend_byte_r;
    pend_off_nxt  = pend_off_r;
    pend_held_nxt = pend_held_r;
    ov_nxt        = ov_r && !out_tready;
    od_nxt        = od_r;
    ou_nxt        = ou_r;
    ol_nxt        = ol_r;
    ring_ctl      = '0;
    case (st_r)
      S_IDLE: begin
        // drop every request once the stream is closed
        if (in_acc && !closed_r) begin
          if (in_tlast && in_tuser[1]) begin
            st_nxt = S_EOF;
          end else if (in_tuser[0]) begin
            st_nxt = S_DIST;
          end else if (in_tlast) begin
            st_nxt = S_DRAIN;
          end
        end
      end
      S_EOF: begin
        final_nxt = alu_res;
        known_nxt = 1'b1;
        st_nxt    = rq_has_r ? S_DIST : S_DRAIN;
      end
      S_DIST: begin
        dist_nxt = alu_res;
        ok_nxt   = (alu_res[sbr_pkg::OFS_W-1:sbr_pkg::CNT_W] == '0) &&
                   (alu_res[sbr_pkg::CNT_W-1:0] < win_eff);
        st_nxt   = S_LIM;
      end
      S_LIM: begin
        // drop a byte at or beyond the known final offset
        if (known_r && dist_r >= alu_res) begin
          ok_nxt = 1'b0;
        end
        st_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (ok_r && !valid_marks[wr_idx]) begin
          ring_ctl.wr = 1'b1;
          held_nxt    = held_r + 1'b1;
        end
        st_nxt = rq_last_r ? S_DRAIN : S_IDLE;
      end
      S_DRAIN: begin
        if (!ov_r) begin
          if (pend_v_r) begin
            ov_nxt     = 1'b1;
            od_nxt     = {pend_held_r, !more && at_final, pend_off_r, pend_byte_r};
            ou_nxt     = 1'b1;
            ol_nxt     = !more;
            pend_v_nxt = 1'b0;
          end else if (!more && at_final) begin
            // close with nothing emitted
            ov_nxt = 1'b1;
            od_nxt = {held_r, 1'b1, ne_r, {sbr_pkg::BYTE_W{1'b0}}};
            ou_nxt = 1'b0;
            ol_nxt = 1'b1;
          end
          if (more) begin
            ring_ctl.rd = 1'b1;
            st_nxt      = S_EMIT;
          end else begin
            closed_nxt = at_final;
            st_nxt     = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        ring_ctl.clr  = 1'b1;
        pend_v_nxt    = 1'b1;
        pend_byte_nxt = rd_data;
        pend_off_nxt  = ne_r;
        pend_held_nxt = held_r - 1'b1;
        held_nxt      = held_r - 1'b1;
        ne_nxt        = alu_res;
        head_nxt      = (head_r == RingTop) ? '0 : head_r + 1'b1;
        st_nxt        = S_DRAIN;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      win_size_r <= sbr_pkg::CNT_W'(64);
      ne_r       <= '0;
      final_r    <= '0;
      known_r    <= 1'b0;
      held_r     <= '0;
      closed_r   <= 1'b0;
      head_r     <= '0;
      pend_v_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      ne_r       <= ne_nxt;
      final_r    <= final_nxt;
      known_r    <= known_nxt;
      held_r     <= held_nxt;
      closed_r   <= closed_nxt;
      head_r     <= head_nxt;
      pend_v_r   <= pend_v_nxt;
      ov_r       <= ov_nxt;
      if (cfg_wr_en) begin
        win_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rq_byte_r <= in_tdata[sbr_pkg::BYTE_W-1:0];
      rq_off_r  <= in_tdata[sbr_pkg::IN_DATA_W-1:sbr_pkg::BYTE_W];
      rq_has_r  <= in_tuser[0];
      rq_last_r <= in_tlast;
    end
    dist_r      <= dist_nxt;
    ok_r        <= ok_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_off_r  <= pend_off_nxt;
    pend_held_r <= pend_held_nxt;
    od_r        <= od_nxt;
    ou_r        <= ou_nxt;
    ol_r        <= ol_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule

// ===== rtl/sbr_checker.sv =====
// ----------------------------------------------------------------------------
// sbr_checker
// Port-level checks of the stream byte reassembler, bound to the top level.
// ----------------------------------------------------------------------------
module sbr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sbr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a close-only result ends the run and reports the stream closed
  a_close_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[40])
    else $error("close-only result without last or closed");

  // every result that is not last carries a byte
  a_mid_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser && !out_tdata[40])
    else $error("mid-run result without data or already closed");

  // nothing follows the result that closes the stream
  a_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[40] |=> !out_tvalid)
    else $error("result after stream close");

endmodule

bind stream_byte_reassembler_unit sbr_checker u_sbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== test/tb_stream_byte_reassembler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_byte_reassembler_unit
// Drives byte requests tagged with stream offsets into the reassembler and
// checks every drained byte and close result against an in-bench model of the
// window, the ring, the end-of-stream mark and the close flag.
// ----------------------------------------------------------------------------
module tb_stream_byte_reassembler_unit;

  localparam int unsigned RING        = 64;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned REQ_TARGET  = 270;

  typedef struct {
    logic [sbr_pkg::BYTE_W-1:0] seg_byte;
    logic                       has_byte;
    logic [sbr_pkg::OFS_W-1:0]  ofs;
    logic                       seg_last;
    logic                       eof_here;
  } seg_req_t;

  typedef struct packed {
    logic [sbr_pkg::BYTE_W-1:0] data;
    logic                       data_ok;
    logic [sbr_pkg::OFS_W-1:0]  ofs;
    logic                       run_last;
    logic                       closed;
    logic [sbr_pkg::CNT_W-1:0]  pending;
  } drain_res_t;

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           cfg_wr_en   = 1'b0;
  logic [sbr_pkg::CNT_W-1:0]      cfg_wr_data = '0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [sbr_pkg::IN_DATA_W-1:0]  in_tdata    = '0;   // seg_byte, stream_offset
  logic [sbr_pkg::IN_USER_W-1:0]  in_tuser    = '0;   // has_byte, eof_here
  logic                           in_tlast    = 1'b0; // seg_last
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  // out_byte, out_offset, stream_closed, pending_count
  logic [sbr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;          // out_valid
  logic                           out_tlast;          // run_last

  stream_byte_reassembler_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // reassembly state as the block should hold it
  logic [sbr_pkg::BYTE_W-1:0] ring_byte [RING];
  bit                         ring_mark [RING];
  logic [sbr_pkg::OFS_W-1:0]  next_ofs   = '0;
  logic [sbr_pkg::OFS_W-1:0]  end_ofs    = '0;
  bit                         end_known  = 1'b0;
  logic [sbr_pkg::CNT_W-1:0]  held_cnt   = '0;
  bit                         closed     = 1'b0;
  logic [5:0]                 head       = '0;
  logic [sbr_pkg::CNT_W-1:0]  window_reg = 7'd64;

  seg_req_t    req_q [$];
  drain_res_t  drain_q [$];
  int unsigned seg_at [$];
  int unsigned seg_len [$];

  bit          in_took;
  bit          idle_on = 1'b1;
  int unsigned send_gap, recv_gap, long_hold;
  int unsigned hold_asked, hold_served;
  int unsigned quiet;
  int unsigned mismatches, reqs_made, reqs_taken, results_seen, bytes_seen, closes_seen;
  int unsigned run_len, longest_run, windows_set;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic take_request(input seg_req_t r);
    logic [sbr_pkg::OFS_W-1:0] ofs_dist;
    int unsigned               win;
    bit                        keep;
    logic [5:0]                slot;
    drain_res_t                run [$];
    drain_res_t                res;
    if (closed) return;
    // the end mark lands before the byte is judged
    if (r.seg_last && r.eof_here) begin
      end_ofs   = r.ofs + sbr_pkg::OFS_W'(r.has_byte);
      end_known = 1'b1;
    end
    if (r.has_byte) begin
      ofs_dist = r.ofs - next_ofs;
      win      = (window_reg > RING) ? RING : window_reg;
      keep     = ofs_dist < win;
      if (end_known && ofs_dist >= end_ofs - next_ofs) keep = 1'b0;
      if (keep) begin
        slot = head + ofs_dist[5:0];
        if (!ring_mark[slot]) begin
          ring_byte[slot] = r.seg_byte;
          ring_mark[slot] = 1'b1;
          held_cnt++;
        end
      end
    end
    if (!r.seg_last) return;
    while (run.size() < RING && ring_mark[head] && !(end_known && next_ofs == end_ofs)) begin
      ring_mark[head] = 1'b0;
      held_cnt--;
      res          = '0;
      res.data     = ring_byte[head];
      res.data_ok  = 1'b1;
      res.ofs      = next_ofs;
      res.pending  = held_cnt;
      run.push_back(res);
      next_ofs++;
      head++;
    end
    if (end_known && next_ofs == end_ofs) closed = 1'b1;
    if (run.size() > 0) begin
      run[run.size()-1].run_last = 1'b1;
      run[run.size()-1].closed   = closed;
    end else if (closed) begin
      res          = '0;
      res.ofs      = next_ofs;
      res.run_last = 1'b1;
      res.closed   = 1'b1;
      res.pending  = held_cnt;
      run.push_back(res);
    end
    foreach (run[i]) drain_q.push_back(run[i]);
  endtask

  task automatic report_bad(input string why, input drain_res_t want, input drain_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want byte %h valid %b ofs %h last %b closed %b pending %0d",
               why, want.data, want.data_ok, want.ofs, want.run_last, want.closed,
               want.pending);
      $display("%s: got  byte %h valid %b ofs %h last %b closed %b pending %0d",
               why, got.data, got.data_ok, got.ofs, got.run_last, got.closed, got.pending);
    end
  endtask

  // monitor: predict on each accepted request, then check each accepted result
  always @(posedge clk) begin
    seg_req_t   r;
    drain_res_t got;
    drain_res_t want;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_tvalid && in_tready;
      if (in_took) begin
        r.seg_byte = in_tdata[7:0];
        r.ofs      = in_tdata[39:8];
        r.has_byte = in_tuser[0];
        r.eof_here = in_tuser[1];
        r.seg_last = in_tlast;
        take_request(r);
        reqs_taken++;
      end
      if (out_tvalid && out_tready) begin
        got.data     = out_tdata[7:0];
        got.ofs      = out_tdata[39:8];
        got.closed   = out_tdata[40];
        got.pending  = out_tdata[47:41];
        got.data_ok  = out_tuser;
        got.run_last = out_tlast;
        results_seen++;
        run_len++;
        if (got.data_ok) bytes_seen++;
        else closes_seen++;
        if (got.run_last) begin
          if (run_len > longest_run) longest_run = run_len;
          run_len = 0;
        end
        if (drain_q.size() == 0) begin
          report_bad("unexpected result", '0, got);
        end else begin
          want = drain_q.pop_front();
          if (got !== want) report_bad("result mismatch", want, got);
        end
      end
    end
  end

  // driver: hold a request until taken, then advance or idle
  always @(negedge clk) begin
    seg_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        r = req_q.pop_front();
        in_tdata  <= {r.ofs, r.seg_byte};
        in_tuser  <= {r.eof_here, r.has_byte};
        in_tlast  <= r.seg_last;
        in_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      long_hold = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold--;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic void push_req(input logic [sbr_pkg::OFS_W-1:0] ofs,
                                   input logic [sbr_pkg::BYTE_W-1:0] b,
                                   input bit has, input bit last, input bit eof);
    seg_req_t r;
    r.seg_byte = b;
    r.has_byte = has;
    r.ofs      = ofs;
    r.seg_last = last;
    r.eof_here = eof;
    req_q.push_back(r);
    reqs_made++;
  endfunction

  function automatic void push_segment(input logic [sbr_pkg::OFS_W-1:0] start,
                                       input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      push_req(start + i, sbr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, i == len - 1,
               1'b0);
  endfunction

  // cut [0, len) into pieces of 1 to 8 bytes, shuffled unless in_order
  function automatic void plan_segments(input int unsigned len, input bit in_order);
    int unsigned k, sl, j, t;
    seg_at.delete();
    seg_len.delete();
    k = 0;
    while (k < len) begin
      sl = $urandom_range(1, 8);
      if (k + sl > len) sl = len - k;
      seg_at.push_back(k);
      seg_len.push_back(sl);
      k += sl;
    end
    if (!in_order) begin
      for (int i = seg_at.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = seg_at[i];  seg_at[i]  = seg_at[j];  seg_at[j]  = t;
        t = seg_len[i]; seg_len[i] = seg_len[j]; seg_len[j] = t;
      end
    end
  endfunction

  function automatic void send_plan(input logic [sbr_pkg::OFS_W-1:0] base, input bit extras);
    bit last;
    foreach (seg_at[i]) begin
      push_segment(base + seg_at[i], seg_len[i]);
      if (extras) begin
        // resend with fresh data: the held bytes must win
        if ($urandom_range(0, 5) == 0) push_segment(base + seg_at[i], seg_len[i]);
        if ($urandom_range(0, 4) == 0) begin
          last = 1'($urandom_range(0, 1));
          push_req($urandom(), sbr_pkg::BYTE_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), last,
                   last ? 1'b0 : 1'($urandom_range(0, 1)));
        end
        // end mark behind the stream: must never close it
        if (base >= 2 && $urandom_range(0, 11) == 0)
          push_req($urandom_range(0, base - 2), sbr_pkg::BYTE_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b1, 1'b1);
      end
    end
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (!(req_q.size() == 0 && (!in_tvalid || in_took) && drain_q.size() == 0));
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [sbr_pkg::CNT_W-1:0] w);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    window_reg = w;
    windows_set++;
  endtask

  initial begin
    logic [sbr_pkg::OFS_W-1:0] base;
    logic [sbr_pkg::CNT_W-1:0] w;
    int unsigned               len, phase;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    set_window(7'd64);
    push_req(0, 8'h00, 1'b1, 1'b0, 1'b0);
    push_req(1, 8'hFF, 1'b1, 1'b0, 1'b0);
    push_req(2, 8'hA5, 1'b1, 1'b1, 1'b0);
    push_req(5, 8'h55, 1'b1, 1'b1, 1'b0);             // hole ahead: nothing drains
    push_req(4, 8'h11, 1'b1, 1'b0, 1'b0);
    push_req(4, 8'h22, 1'b1, 1'b0, 1'b0);             // duplicate offset, first byte stays
    push_req(3, 8'h33, 1'b1, 1'b1, 1'b0);
    push_req(70, 8'h77, 1'b1, 1'b1, 1'b0);            // one past the window
    push_req(32'hFFFF_FFFF, 8'h88, 1'b1, 1'b1, 1'b0); // behind next, wraps
    push_req(69, 8'h99, 1'b1, 1'b0, 1'b0);            // far edge of the window
    push_req(32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b0); // empty segment end
    push_req(32'hDEAD_BEEF, 8'h00, 1'b0, 1'b0, 1'b1); // end mark without segment end
    push_req(2, 8'h00, 1'b0, 1'b1, 1'b1);             // end behind the stream
    push_req(6, 8'hC3, 1'b1, 1'b1, 1'b0);
    push_req(32'hFFFF_FFFF, 8'h01, 1'b1, 1'b1, 1'b1); // end offset wraps to zero
    push_req(9, 8'h00, 1'b0, 1'b1, 1'b1);             // empty end segment ahead of a hole
    push_req(10, 8'hE7, 1'b1, 1'b0, 1'b0);            // past the end: drop
    push_req(8, 8'h3C, 1'b1, 1'b1, 1'b0);
    push_req(1, 8'h00, 1'b0, 1'b1, 1'b1);             // later end mark overwrites
    push_req(7, 8'h7E, 1'b1, 1'b1, 1'b0);

    set_window(7'd0);
    push_req(next_ofs, 8'hF0, 1'b1, 1'b1, 1'b0);
    set_window(7'd127);
    push_req(next_ofs + 63, 8'h0F, 1'b1, 1'b0, 1'b0);
    push_req(next_ofs + 64, 8'hAA, 1'b1, 1'b1, 1'b0);
    set_window(7'd1);
    push_req(next_ofs + 1, 8'h5A, 1'b1, 1'b0, 1'b0);
    push_req(next_ofs, 8'hC0, 1'b1, 1'b1, 1'b0);

    // random phases, each starting from a drained block
    phase = 0;
    while (reqs_made < REQ_TARGET) begin
      if (reqs_made > REQ_TARGET * 4 / 5) idle_on = 1'b0;
      if (phase == 2) begin
        // fill the whole window behind a hole, then close the hole under a long stall
        set_window(7'd64);
        base = next_ofs;
        plan_segments(63, 1'b0);
        send_plan(base + 1, 1'b0);
        while (req_q.size() != 0) @(posedge clk);
        hold_asked++;
        push_req(base, sbr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
        push_segment(base + 64, 8);
      end else begin
        case ($urandom_range(0, 9))
          0:       w = 7'd1;
          1:       w = 7'd2;
          2:       w = sbr_pkg::CNT_W'($urandom_range(65, 127));
          3:       w = 7'd64;
          default: w = sbr_pkg::CNT_W'($urandom_range(8, 64));
        endcase
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 40);
        set_window(w);
        base = next_ofs;
        plan_segments(len, $urandom_range(0, 2) == 0);
        send_plan(base, 1'b1);
      end
      phase++;
    end

    // closing sequence
    set_window(7'd64);
    base = next_ofs;
    // stays pending past the end
    push_req(base + 7, sbr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
    // end ahead of a hole: stay open
    push_req(base + 5, 8'h00, 1'b0, 1'b1, 1'b1);
    // past the end: drop
    push_req(base + 6, sbr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
    // move the end behind again
    push_req(base - 1, 8'h00, 1'b0, 1'b1, 1'b1);
    push_segment(base, 5);
    wait_idle();
    // close with nothing to emit
    push_req(next_ofs, 8'h00, 1'b0, 1'b1, 1'b1);
    // ignored once closed
    push_req(next_ofs, sbr_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
    push_req(next_ofs + 1, 8'h00, 1'b0, 1'b1, 1'b1);
    wait_idle();

    if (drain_q.size() != 0) begin
      $display("%0d expected results never arrived", drain_q.size());
      mismatches += drain_q.size();
    end
    $display("covered %0d requests over %0d window settings, %0d results checked",
             reqs_taken, windows_set, results_seen);
    $display("%0d bytes and %0d close-only results, longest drain %0d, stream closed %0b",
             bytes_seen, closes_seen, longest_run, closed);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sbr_pkg.sv
rtl/sbr_alu.sv
rtl/sbr_ring.sv
rtl/stream_byte_reassembler_unit.sv
rtl/sbr_checker.sv
test/tb_stream_byte_reassembler_unit.sv
